// ===== design/bba_pkg.sv =====
// shared codes, widths and control types of the buddy allocator
`default_nettype none
package bba_pkg;
	localparam logic [1:0] ND_ABSENT = 2'd0;
	localparam logic [1:0] ND_FREE   = 2'd1;
	localparam logic [1:0] ND_BUSY   = 2'd2;
	localparam logic [1:0] ND_SPLIT  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFIT  = 2'd1;
	localparam logic [1:0] ST_BADOFF = 2'd2;

	localparam int REQ_W  = 16;
	localparam int OFF_W  = 10;
	localparam int SIZE_W = 11;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLR,
		CMD_ROOT,
		CMD_LOAD,
		CMD_ROUND,
		CMD_SINIT,
		CMD_SRD,
		CMD_SNEXT,
		CMD_SPLIT_A,
		CMD_SPLIT_B,
		CMD_MARK,
		CMD_FAIL,
		CMD_FINIT,
		CMD_FRD,
		CMD_FNEXT,
		CMD_FMARK,
		CMD_MRD,
		CMD_MW1,
		CMD_MW2,
		CMD_MW3,
		CMD_PUSH
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic round_done;
		logic round_fail;
		logic mem_free;
		logic mem_busy;
		logic lvl_last;
		logic lvl_zero;
		logic split_done;
		logic off_bad;
		logic lvl_over;
		logic aligned;
		logic idx_root;
		logic out_full;
	} stat_t;
endpackage
`default_nettype wire

// ===== design/bba_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== design/bba_dp.sv =====
// datapath: node-state ram, walk registers and result register
`default_nettype none
module bba_dp #(
	parameter int POOL_SIZE = 1024,
	parameter int MIN_BLOCK = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bba_pkg::cmd_t               cmd,
	output bba_pkg::stat_t                   stat,
	input  wire logic                        req_type,
	input  wire logic [bba_pkg::REQ_W-1:0]   request_size,
	input  wire logic [bba_pkg::OFF_W-1:0]   block_offset,
	input  wire logic                        rsp_ready,
	output logic                             rsp_valid,
	output logic      [bba_pkg::OFF_W-1:0]   result_offset,
	output logic      [bba_pkg::SIZE_W-1:0]  granted_size,
	output logic      [1:0]                  status
);
	localparam int PL    = $clog2(POOL_SIZE);
	localparam int ML    = $clog2(MIN_BLOCK);
	localparam int MAXD  = PL - ML;
	localparam int IW    = MAXD + 1;
	localparam int DEPTH = 2 ** IW;
	localparam int DW    = $clog2(MAXD + 2);
	localparam int CW    = (PL + 1 > bba_pkg::REQ_W) ? PL + 1 : bba_pkg::REQ_W;
	localparam int OXW   = (PL > bba_pkg::OFF_W) ? PL : bba_pkg::OFF_W;
	localparam int SHW   = $clog2(PL + 1);

	logic                        type_q;
	logic [bba_pkg::REQ_W-1:0]   req_q;
	logic [bba_pkg::OFF_W-1:0]   off_q;
	logic [IW-1:0]               idx_q;
	logic [DW-1:0]               lvl_q;
	logic [DW-1:0]               wd_q;
	logic [CW-1:0]               want_q;
	logic                        fail_q;
	logic                        rsp_valid_q;
	logic [bba_pkg::OFF_W-1:0]   res_off_q;
	logic [bba_pkg::SIZE_W-1:0]  res_size_q;
	logic [1:0]                  res_st_q;

	logic            grow;
	logic [IW-1:0]   lvl_pow;
	logic [IW-1:0]   last_idx;
	logic [OXW-1:0]  off_ext;
	logic [SHW-1:0]  sh;
	logic [OXW-1:0]  size_mask;
	logic [IW-1:0]   idx_f;
	logic [31:0]     alloc_off;
	logic [31:0]     free_size;
	logic            push_ok;

	logic            mem_we;
	logic [IW-1:0]   mem_addr;
	logic [1:0]      mem_wdata;
	logic [1:0]      mem_rdata;

	bba_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign grow      = (want_q < CW'(req_q)) && (wd_q != '0);
	assign lvl_pow   = IW'(1) << lvl_q;
	assign last_idx  = (lvl_pow << 1) - IW'(1);
	assign off_ext   = OXW'(off_q);
	assign sh        = SHW'(PL) - SHW'(lvl_q);
	assign size_mask = (OXW'(1) << sh) - OXW'(1);
	assign idx_f     = lvl_pow + IW'(off_ext >> sh);
	assign alloc_off = 32'(idx_q ^ lvl_pow) << sh;
	assign free_size = 32'(POOL_SIZE) >> lvl_q;
	assign push_ok   = !rsp_valid_q || rsp_ready;

	always_comb begin
		stat.clr_last   = (idx_q == '1);
		stat.round_done = !grow;
		stat.round_fail = (want_q < CW'(req_q));
		stat.mem_free   = (mem_rdata == bba_pkg::ND_FREE);
		stat.mem_busy   = (mem_rdata == bba_pkg::ND_BUSY);
		stat.lvl_last   = (idx_q == last_idx);
		stat.lvl_zero   = (lvl_q == '0);
		stat.split_done = (lvl_q == wd_q);
		stat.off_bad    = (32'(off_q) >= 32'(POOL_SIZE));
		stat.lvl_over   = (lvl_q > DW'(MAXD));
		stat.aligned    = ((off_ext & size_mask) == '0);
		stat.idx_root   = (idx_q == IW'(1));
		stat.out_full   = !push_ok;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q;
		mem_wdata = bba_pkg::ND_ABSENT;
		case (cmd)
			bba_pkg::CMD_CLR: begin
				mem_we = 1'b1;
			end
			bba_pkg::CMD_ROOT: begin
				mem_we    = 1'b1;
				mem_addr  = IW'(1);
				mem_wdata = bba_pkg::ND_FREE;
			end
			bba_pkg::CMD_SPLIT_A: begin
				mem_we    = 1'b1;
				mem_wdata = bba_pkg::ND_SPLIT;
			end
			bba_pkg::CMD_SPLIT_B: begin
				mem_we    = 1'b1;
				mem_addr  = (idx_q << 1) | IW'(1);
				mem_wdata = bba_pkg::ND_FREE;
			end
			bba_pkg::CMD_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = bba_pkg::ND_BUSY;
			end
			bba_pkg::CMD_FRD: begin
				mem_addr = idx_f;
			end
			bba_pkg::CMD_FMARK: begin
				mem_we    = 1'b1;
				mem_wdata = bba_pkg::ND_FREE;
			end
			bba_pkg::CMD_MRD: begin
				mem_addr = idx_q ^ IW'(1);
			end
			bba_pkg::CMD_MW1: begin
				mem_we = 1'b1;
			end
			bba_pkg::CMD_MW2: begin
				mem_we   = 1'b1;
				mem_addr = idx_q ^ IW'(1);
			end
			bba_pkg::CMD_MW3: begin
				mem_we    = 1'b1;
				mem_addr  = idx_q >> 1;
				mem_wdata = bba_pkg::ND_FREE;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// walk registers; idx_q doubles as the clearing counter after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			case (cmd)
				bba_pkg::CMD_CLR:     idx_q <= idx_q + IW'(1);
				bba_pkg::CMD_SINIT:   idx_q <= IW'(1) << wd_q;
				bba_pkg::CMD_SNEXT:   idx_q <= stat.lvl_last ? (lvl_pow >> 1) : idx_q + IW'(1);
				bba_pkg::CMD_SPLIT_B: idx_q <= idx_q << 1;
				bba_pkg::CMD_FRD:     idx_q <= idx_f;
				bba_pkg::CMD_MW3:     idx_q <= idx_q >> 1;
				default:              idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			bba_pkg::CMD_LOAD: begin
				type_q <= req_type;
				req_q  <= request_size;
				off_q  <= block_offset;
				want_q <= CW'(MIN_BLOCK);
				wd_q   <= DW'(MAXD);
				fail_q <= 1'b0;
			end
			bba_pkg::CMD_ROUND: begin
				if (grow) begin
					want_q <= want_q << 1;
					wd_q   <= wd_q - DW'(1);
				end
			end
			bba_pkg::CMD_SINIT:   lvl_q  <= wd_q;
			bba_pkg::CMD_SNEXT:   if (stat.lvl_last) lvl_q <= lvl_q - DW'(1);
			bba_pkg::CMD_SPLIT_B: lvl_q  <= lvl_q + DW'(1);
			bba_pkg::CMD_FINIT:   lvl_q  <= '0;
			bba_pkg::CMD_FNEXT:   lvl_q  <= lvl_q + DW'(1);
			bba_pkg::CMD_FAIL:    fail_q <= 1'b1;
			default: begin
				fail_q <= fail_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd == bba_pkg::CMD_PUSH) begin
			if (fail_q) begin
				res_off_q  <= type_q ? off_q : '0;
				res_size_q <= '0;
				res_st_q   <= type_q ? bba_pkg::ST_BADOFF : bba_pkg::ST_NOFIT;
			end else if (type_q) begin
				res_off_q  <= off_q;
				res_size_q <= free_size[bba_pkg::SIZE_W-1:0];
				res_st_q   <= bba_pkg::ST_OK;
			end else begin
				res_off_q  <= alloc_off[bba_pkg::OFF_W-1:0];
				res_size_q <= want_q[bba_pkg::SIZE_W-1:0];
				res_st_q   <= bba_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd == bba_pkg::CMD_PUSH) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign result_offset = res_off_q;
	assign granted_size  = res_size_q;
	assign status        = res_st_q;
endmodule
`default_nettype wire

// ===== design/bba_ctrl.sv =====
// controller: sequences clearing, search, split and merge steps
`default_nettype none
module bba_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_type,
	output logic                req_ready,
	input  wire bba_pkg::stat_t stat,
	output bba_pkg::cmd_t       cmd
);
	typedef enum logic [15:0] {
		S_CLR    = 16'h0001,
		S_ROOT   = 16'h0002,
		S_IDLE   = 16'h0004,
		S_ROUND  = 16'h0008,
		S_SRD    = 16'h0010,
		S_SCHK   = 16'h0020,
		S_SPL    = 16'h0040,
		S_SPB    = 16'h0080,
		S_FSTART = 16'h0100,
		S_FLVL   = 16'h0200,
		S_FCHK   = 16'h0400,
		S_MRD    = 16'h0800,
		S_MCHK   = 16'h1000,
		S_MW2    = 16'h2000,
		S_MW3    = 16'h4000,
		S_PUSH   = 16'h8000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = bba_pkg::CMD_NONE;
		req_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd = bba_pkg::CMD_CLR;
				if (stat.clr_last) state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd     = bba_pkg::CMD_ROOT;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd     = bba_pkg::CMD_LOAD;
					state_d = req_type ? S_FSTART : S_ROUND;
				end
			end
			S_ROUND: begin
				if (!stat.round_done) begin
					cmd = bba_pkg::CMD_ROUND;
				end else if (stat.round_fail) begin
					cmd     = bba_pkg::CMD_FAIL;
					state_d = S_PUSH;
				end else begin
					cmd     = bba_pkg::CMD_SINIT;
					state_d = S_SRD;
				end
			end
			S_SRD: begin
				cmd     = bba_pkg::CMD_SRD;
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (stat.mem_free) begin
					state_d = S_SPL;
				end else if (stat.lvl_last && stat.lvl_zero) begin
					cmd     = bba_pkg::CMD_FAIL;
					state_d = S_PUSH;
				end else begin
					cmd     = bba_pkg::CMD_SNEXT;
					state_d = S_SRD;
				end
			end
			S_SPL: begin
				if (stat.split_done) begin
					cmd     = bba_pkg::CMD_MARK;
					state_d = S_PUSH;
				end else begin
					cmd     = bba_pkg::CMD_SPLIT_A;
					state_d = S_SPB;
				end
			end
			S_SPB: begin
				cmd     = bba_pkg::CMD_SPLIT_B;
				state_d = S_SPL;
			end
			S_FSTART: begin
				if (stat.off_bad) begin
					cmd     = bba_pkg::CMD_FAIL;
					state_d = S_PUSH;
				end else begin
					cmd     = bba_pkg::CMD_FINIT;
					state_d = S_FLVL;
				end
			end
			S_FLVL: begin
				if (stat.lvl_over) begin
					cmd     = bba_pkg::CMD_FAIL;
					state_d = S_PUSH;
				end else if (stat.aligned) begin
					cmd     = bba_pkg::CMD_FRD;
					state_d = S_FCHK;
				end else begin
					cmd = bba_pkg::CMD_FNEXT;
				end
			end
			S_FCHK: begin
				if (stat.mem_busy) begin
					cmd     = bba_pkg::CMD_FMARK;
					state_d = S_MRD;
				end else begin
					cmd     = bba_pkg::CMD_FNEXT;
					state_d = S_FLVL;
				end
			end
			S_MRD: begin
				if (stat.idx_root) begin
					state_d = S_PUSH;
				end else begin
					cmd     = bba_pkg::CMD_MRD;
					state_d = S_MCHK;
				end
			end
			S_MCHK: begin
				// merge only while the buddy is free too
				if (stat.mem_free) begin
					cmd     = bba_pkg::CMD_MW1;
					state_d = S_MW2;
				end else begin
					state_d = S_PUSH;
				end
			end
			S_MW2: begin
				cmd     = bba_pkg::CMD_MW2;
				state_d = S_MW3;
			end
			S_MW3: begin
				cmd     = bba_pkg::CMD_MW3;
				state_d = S_MRD;
			end
			S_PUSH: begin
				if (!stat.out_full) begin
					cmd     = bba_pkg::CMD_PUSH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== design/buddy_block_allocator.sv =====
// top level of the binary buddy block allocator
//
// requests enter on req_valid/req_ready (req_type, request_size, block_offset),
// one result per request leaves on rsp_valid/rsp_ready (result_offset,
// granted_size, status). one request is worked on at a time.
// after reset a clearing pass writes every node of the state ram, one per
// cycle, with req_ready low throughout.
// allocate: rounding steps, then a scan of tree nodes (one ram read each,
// up to every node at the wanted level and all levels above it), then the
// splits. free: a level step per unaligned tree level, a ram read per
// aligned level, then per merge a buddy read and three writes.
// the node ram is single-port: one access per cycle.
// a finished result sits in the output register; the next request is taken
// while it waits. a stalled receiver holds the controller before the next
// result is written, and no result is lost or dropped.
`default_nettype none
module buddy_block_allocator #(
	parameter int POOL_SIZE = 1024,
	parameter int MIN_BLOCK = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire logic                        req_type,
	input  wire logic [bba_pkg::REQ_W-1:0]   request_size,
	input  wire logic [bba_pkg::OFF_W-1:0]   block_offset,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output logic      [bba_pkg::OFF_W-1:0]   result_offset,
	output logic      [bba_pkg::SIZE_W-1:0]  granted_size,
	output logic      [1:0]                  status
);
	bba_pkg::cmd_t  cmd;
	bba_pkg::stat_t stat;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bba_dp #(.POOL_SIZE(POOL_SIZE), .MIN_BLOCK(MIN_BLOCK)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.request_size  (request_size),
		.block_offset  (block_offset),
		.rsp_ready     (rsp_ready),
		.rsp_valid     (rsp_valid),
		.result_offset (result_offset),
		.granted_size  (granted_size),
		.status        (status)
	);
endmodule
`default_nettype wire

// ===== design/bba_chk.sv =====
// port-level checker for the buddy allocator, bound to the top level
`default_nettype none
module bba_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [bba_pkg::OFF_W-1:0]  result_offset,
	input wire logic [bba_pkg::SIZE_W-1:0] granted_size,
	input wire logic [1:0]                 status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_offset)
			&& $stable(granted_size) && $stable(status))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == bba_pkg::ST_OK) || (status == bba_pkg::ST_NOFIT)
			|| (status == bba_pkg::ST_BADOFF))
		else $error("undefined status code");

	a_nofit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == bba_pkg::ST_NOFIT |-> result_offset == '0
			&& granted_size == '0)
		else $error("failed allocate carries a block");

	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == bba_pkg::ST_OK |-> granted_size != '0)
		else $error("granted transaction with zero size");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == bba_pkg::ST_BADOFF |-> granted_size == '0)
		else $error("rejected free carries a size");
endmodule

bind buddy_block_allocator bba_chk u_bba_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp_valid),
	.rsp_ready     (rsp_ready),
	.result_offset (result_offset),
	.granted_size  (granted_size),
	.status        (status)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the buddy block allocator
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	localparam int POOL = 1024;
	localparam int MINB = 4;
	localparam int NODES = 2 * (POOL / MINB);
	localparam int MAXD = 8;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic                      kind;
		logic [bba_pkg::REQ_W-1:0] size;
		logic [bba_pkg::OFF_W-1:0] offset;
	} alloc_req_t;

	typedef struct packed {
		logic [bba_pkg::OFF_W-1:0]  offset;
		logic [bba_pkg::SIZE_W-1:0] size;
		logic [1:0]                 code;
	} alloc_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic req_type = 1'b0;
	logic [bba_pkg::REQ_W-1:0] request_size = '0;
	logic [bba_pkg::OFF_W-1:0] block_offset = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [bba_pkg::OFF_W-1:0] result_offset;
	logic [bba_pkg::SIZE_W-1:0] granted_size;
	logic [1:0] status;

	alloc_req_t pending_reqs[$];
	alloc_rsp_t expected_rsps[$];
	logic [1:0] tree[NODES];
	int live_offsets[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int calm_until = 0;
	int cycle_no = 0;
	bit stim_done = 0;

	buddy_block_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
		.request_size(request_size), .block_offset(block_offset),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.result_offset(result_offset), .granted_size(granted_size), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic alloc_rsp_t buddy_alloc(int want_units);
		alloc_rsp_t r;
		int want, wd, idx, d;
		want = MINB;
		wd = MAXD;
		r = '0;
		r.code = bba_pkg::ST_NOFIT;
		while (want < want_units && wd > 0) begin
			want = want << 1;
			wd--;
		end
		if (want < want_units)
			return r;
		for (d = wd; d >= 0; d--) begin
			for (int i = (1 << d); i < (2 << d); i++) begin
				if (tree[i] == bba_pkg::ND_FREE) begin
					idx = i;
					while (d < wd) begin
						tree[idx] = bba_pkg::ND_SPLIT;
						tree[2 * idx + 1] = bba_pkg::ND_FREE;
						idx = 2 * idx;
						d++;
					end
					tree[idx] = bba_pkg::ND_BUSY;
					r.size = bba_pkg::SIZE_W'(POOL >> d);
					r.offset = bba_pkg::OFF_W'((idx - (1 << d)) * (POOL >> d));
					r.code = bba_pkg::ST_OK;
					return r;
				end
			end
		end
		return r;
	endfunction

	function automatic alloc_rsp_t buddy_free(int off);
		alloc_rsp_t r;
		int sz, idx, p;
		r.offset = bba_pkg::OFF_W'(off);
		r.size = '0;
		r.code = bba_pkg::ST_BADOFF;
		for (int d = 0; d <= MAXD; d++) begin
			sz = POOL >> d;
			if (off % sz != 0)
				continue;
			idx = (1 << d) + off / sz;
			if (tree[idx] == bba_pkg::ND_BUSY) begin
				tree[idx] = bba_pkg::ND_FREE;
				while (idx > 1) begin
					p = idx >> 1;
					if (tree[2 * p] != bba_pkg::ND_FREE || tree[2 * p + 1] != bba_pkg::ND_FREE)
						break;
					tree[2 * p] = bba_pkg::ND_ABSENT;
					tree[2 * p + 1] = bba_pkg::ND_ABSENT;
					tree[p] = bba_pkg::ND_FREE;
					idx = p;
				end
				r.size = bba_pkg::SIZE_W'(sz);
				r.code = bba_pkg::ST_OK;
				return r;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic logic idle_roll();
		return (cycle_no > calm_until) && ($urandom_range(0, 99) < 15);
	endfunction

	// driver
	always @(posedge clk) begin
		alloc_req_t nxt;
		alloc_rsp_t e;
		cycle_no <= cycle_no + 1;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				nxt = pending_reqs.pop_front();
				e = (nxt.kind == REQ_ALLOC) ? buddy_alloc(nxt.size) : buddy_free(nxt.offset);
				expected_rsps.push_back(e);
			end
			if ((!req_valid || req_ready) && pending_reqs.size() > 0 && !idle_roll()) begin
				req_valid <= 1'b1;
				req_type <= pending_reqs[0].kind;
				request_size <= pending_reqs[0].size;
				block_offset <= pending_reqs[0].offset;
			end else if (req_valid && req_ready) begin
				req_valid <= 1'b0;
			end
			rsp_ready <= !idle_roll();
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		alloc_rsp_t e;
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					e = expected_rsps.pop_front();
					if (result_offset !== e.offset)
						report_mismatch("result_offset", result_offset, e.offset);
					if (granted_size !== e.size)
						report_mismatch("granted_size", granted_size, e.size);
					if (status !== e.code)
						report_mismatch("status", status, e.code);
				end
			end
			if (idle_cycles > WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic push_req(logic kind, int size, int off);
		alloc_req_t r;
		r.kind = kind;
		r.size = bba_pkg::REQ_W'(size);
		r.offset = bba_pkg::OFF_W'(off);
		pending_reqs.push_back(r);
	endtask

	initial begin
		int k, pick, sz;
		foreach (tree[i]) tree[i] = bba_pkg::ND_ABSENT;
		tree[1] = bba_pkg::ND_FREE;
		// directed: whole pool, oversize, zero size, bad frees, splits and merges
		push_req(REQ_ALLOC, 1024, 0);
		push_req(REQ_ALLOC, 1, 0);
		push_req(REQ_FREE, 0, 4);
		push_req(REQ_FREE, 0, 0);
		push_req(REQ_FREE, 0, 0);
		push_req(REQ_ALLOC, 65535, 1023);
		push_req(REQ_ALLOC, 1025, 0);
		push_req(REQ_ALLOC, 0, 1023);
		push_req(REQ_ALLOC, 5, 0);
		push_req(REQ_ALLOC, 3, 0);
		push_req(REQ_ALLOC, 200, 0);
		push_req(REQ_ALLOC, 512, 0);
		push_req(REQ_ALLOC, 512, 0);
		push_req(REQ_FREE, 0, 1023);
		push_req(REQ_FREE, 0, 8);
		push_req(REQ_FREE, 0, 0);
		push_req(REQ_FREE, 0, 4);
		push_req(REQ_FREE, 0, 256);
		push_req(REQ_FREE, 0, 512);
		push_req(REQ_ALLOC, 16'hAAAA, 10'h155);
		push_req(REQ_ALLOC, 16'h5555, 10'h2AA);
		// random: mostly allocs and frees of random 4-aligned offsets, some noise
		for (k = 0; k < 1900; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 1 << $urandom_range(0, 9));
				push_req(REQ_ALLOC, sz, $urandom_range(0, 1023));
				live_offsets.push_back($urandom_range(0, 255) * 4);
			end else if (pick < 85 && live_offsets.size() > 0) begin
				push_req(REQ_FREE, $urandom_range(0, 65535),
					live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
			end else if (pick < 90) begin
				push_req(REQ_FREE, $urandom_range(0, 65535), $urandom_range(0, 63) * 16);
			end else begin
				push_req(REQ_FREE, $urandom_range(0, 65535), $urandom_range(0, 1023));
			end
		end
		calm_until = 1000 + 8000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
